// ===== src/mpbm_pkg.sv =====
package mpbm_pkg;

    localparam int NODE_W     = 8;
    localparam int NODE_COUNT = 256;
    localparam int SYM_W      = 8;
    localparam int CHILD_AW   = NODE_W + SYM_W;
    localparam int CNT_W      = NODE_W + 1;
    localparam int PID_W      = 8;
    localparam int OP_W       = 2;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
    localparam logic [OP_W-1:0] OP_MATCH   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

endpackage

// ===== src/mpbm_ram.sv =====
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/multi_pattern_byte_matcher.sv =====
// multi-pattern byte matcher (aho-corasick) over a 256-node trie
// input channel s_axis: tuser carries the operation (add byte, build links,
// match byte, restart), tdata the data byte and pattern id, tlast marks the
// final byte of a pattern being added
// output channel m_axis: one transaction per input transaction, tdata holds
// match_found, match_pattern and table_full
// one input is worked at a time by a small sequencer sharing the node rams;
// every ram read is registered; the result goes valid on the edge at which
// s_axis_tready rises again, so latency and input spacing are the same
// add reads the child, first-child and last-child rams and allocates a node
// when the edge is missing; restart returns the match state to the root;
// match follows failure links until a child is found or the root is reached;
// build walks the trie breadth first, following failure links while linking
// after reset the child table (65536 entries) and node tables are swept to
// zero, one entry a cycle, and s_axis_tready stays low until the sweep ends
// a result waits in the output register while m_axis_tready is low; the next
// input is taken meanwhile and its work runs, its result waits for the slot
module multi_pattern_byte_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mpbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // data_byte, pattern_id
    input  logic [mpbm_pkg::OP_W-1:0]        s_axis_tuser,  // operation
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mpbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // match_found, match_pattern, table_full
);
    import mpbm_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_A0      = 5'd2;
    localparam logic [4:0] S_A1      = 5'd3;
    localparam logic [4:0] S_A2      = 5'd4;
    localparam logic [4:0] S_B_POP   = 5'd5;
    localparam logic [4:0] S_B_P     = 5'd6;
    localparam logic [4:0] S_B_Q0    = 5'd7;
    localparam logic [4:0] S_B_CHILD = 5'd8;
    localparam logic [4:0] S_B_R0    = 5'd9;
    localparam logic [4:0] S_B_LOOK  = 5'd10;
    localparam logic [4:0] S_B_LOOKW = 5'd11;
    localparam logic [4:0] S_B_RR    = 5'd12;
    localparam logic [4:0] S_B_F     = 5'd13;
    localparam logic [4:0] S_B_F2    = 5'd14;
    localparam logic [4:0] S_B_NEXT  = 5'd15;
    localparam logic [4:0] S_B_NEXTW = 5'd16;
    localparam logic [4:0] S_M_LOOK  = 5'd17;
    localparam logic [4:0] S_M_W     = 5'd18;
    localparam logic [4:0] S_M_FR    = 5'd19;
    localparam logic [4:0] S_M_R     = 5'd20;
    localparam logic [4:0] S_DONE    = 5'd21;

    logic [4:0]          r_state, n_state;
    logic [CHILD_AW-1:0] r_clr, n_clr;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic                r_last, n_last;
    logic [NODE_W-1:0]   r_ins, n_ins;
    logic [NODE_W-1:0]   r_mc, n_mc;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_guard, n_guard;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic [NODE_W-1:0]   r_p, n_p;
    logic [NODE_W-1:0]   r_q, n_q;
    logic [NODE_W-1:0]   r_r, n_r;
    logic [SYM_W-1:0]    r_lbl, n_lbl;
    logic [NODE_W-1:0]   r_c, n_c;
    logic [NODE_W-1:0]   r_s, n_s;
    logic                r_res_found, n_res_found;
    logic [PID_W-1:0]    r_res_pat, n_res_pat;
    logic                r_res_full, n_res_full;
    logic                r_ov, n_ov;
    logic                r_ofound, n_ofound;
    logic [PID_W-1:0]    r_opat, n_opat;
    logic                r_ofull, n_ofull;

    logic                ch_we, ch_re;
    logic [CHILD_AW-1:0] ch_waddr, ch_raddr;
    logic [NODE_W-1:0]   ch_wdata, ch_rdata;

    logic                fl_we, fl_re;
    logic [NODE_W-1:0]   fl_waddr, fl_raddr, fl_wdata, fl_rdata;
    logic                ef_we, ef_re;
    logic [NODE_W-1:0]   ef_waddr, ef_raddr;
    logic                ef_wdata, ef_rdata;
    logic                ow_we, ow_re;
    logic [NODE_W-1:0]   ow_waddr, ow_raddr;
    logic [PID_W-1:0]    ow_wdata, ow_rdata;
    logic                ov_we, ov_re;
    logic [NODE_W-1:0]   ov_waddr, ov_raddr;
    logic                ov_wdata, ov_rdata;
    logic                op_we, op_re;
    logic [NODE_W-1:0]   op_waddr, op_raddr;
    logic [PID_W-1:0]    op_wdata, op_rdata;
    logic                fc_we, fc_re;
    logic [NODE_W-1:0]   fc_waddr, fc_raddr, fc_wdata, fc_rdata;
    logic                ns_we, ns_re;
    logic [NODE_W-1:0]   ns_waddr, ns_raddr, ns_wdata, ns_rdata;
    logic                lc_we, lc_re;
    logic [NODE_W-1:0]   lc_waddr, lc_raddr, lc_wdata, lc_rdata;
    logic                lb_we, lb_re;
    logic [NODE_W-1:0]   lb_waddr, lb_raddr;
    logic [SYM_W-1:0]    lb_wdata, lb_rdata;
    logic                wq_we, wq_re;
    logic [NODE_W-1:0]   wq_waddr, wq_raddr, wq_wdata, wq_rdata;

    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT * NODE_COUNT)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_re(ch_re), .i_raddr(ch_raddr), .o_rdata(ch_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_fail (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_re(fl_re), .i_raddr(fl_raddr), .o_rdata(fl_rdata));
    mpbm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_endf (
        .i_clk(i_clk), .i_we(ef_we), .i_waddr(ef_waddr), .i_wdata(ef_wdata),
        .i_re(ef_re), .i_raddr(ef_raddr), .o_rdata(ef_rdata));
    mpbm_ram #(.WIDTH(PID_W), .DEPTH(NODE_COUNT)) u_own (
        .i_clk(i_clk), .i_we(ow_we), .i_waddr(ow_waddr), .i_wdata(ow_wdata),
        .i_re(ow_re), .i_raddr(ow_raddr), .o_rdata(ow_rdata));
    mpbm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_outv (
        .i_clk(i_clk), .i_we(ov_we), .i_waddr(ov_waddr), .i_wdata(ov_wdata),
        .i_re(ov_re), .i_raddr(ov_raddr), .o_rdata(ov_rdata));
    mpbm_ram #(.WIDTH(PID_W), .DEPTH(NODE_COUNT)) u_outp (
        .i_clk(i_clk), .i_we(op_we), .i_waddr(op_waddr), .i_wdata(op_wdata),
        .i_re(op_re), .i_raddr(op_raddr), .o_rdata(op_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_first (
        .i_clk(i_clk), .i_we(fc_we), .i_waddr(fc_waddr), .i_wdata(fc_wdata),
        .i_re(fc_re), .i_raddr(fc_raddr), .o_rdata(fc_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_sib (
        .i_clk(i_clk), .i_we(ns_we), .i_waddr(ns_waddr), .i_wdata(ns_wdata),
        .i_re(ns_re), .i_raddr(ns_raddr), .o_rdata(ns_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_lastc (
        .i_clk(i_clk), .i_we(lc_we), .i_waddr(lc_waddr), .i_wdata(lc_wdata),
        .i_re(lc_re), .i_raddr(lc_raddr), .o_rdata(lc_rdata));
    mpbm_ram #(.WIDTH(SYM_W), .DEPTH(NODE_COUNT)) u_label (
        .i_clk(i_clk), .i_we(lb_we), .i_waddr(lb_waddr), .i_wdata(lb_wdata),
        .i_re(lb_re), .i_raddr(lb_raddr), .o_rdata(lb_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_queue (
        .i_clk(i_clk), .i_we(wq_we), .i_waddr(wq_waddr), .i_wdata(wq_wdata),
        .i_re(wq_re), .i_raddr(wq_raddr), .o_rdata(wq_rdata));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_ofull, r_opat, r_ofound};

    always_comb begin
        n_state = r_state;  n_clr = r_clr;    n_sym = r_sym;
        n_pid = r_pid;      n_last = r_last;  n_ins = r_ins;    n_mc = r_mc;
        n_used = r_used;    n_head = r_head;  n_tail = r_tail;  n_guard = r_guard;
        n_steps = r_steps;  n_p = r_p;        n_q = r_q;        n_r = r_r;
        n_lbl = r_lbl;      n_c = r_c;        n_s = r_s;
        n_res_found = r_res_found;  n_res_pat = r_res_pat;  n_res_full = r_res_full;
        n_ov = r_ov & ~m_axis_tready;
        n_ofound = r_ofound;  n_opat = r_opat;  n_ofull = r_ofull;

        ch_we = 1'b0; ch_waddr = '0; ch_wdata = '0; ch_re = 1'b0; ch_raddr = '0;
        fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_re = 1'b0; fl_raddr = '0;
        ef_we = 1'b0; ef_waddr = '0; ef_wdata = '0; ef_re = 1'b0; ef_raddr = '0;
        ow_we = 1'b0; ow_waddr = '0; ow_wdata = '0; ow_re = 1'b0; ow_raddr = '0;
        ov_we = 1'b0; ov_waddr = '0; ov_wdata = '0; ov_re = 1'b0; ov_raddr = '0;
        op_we = 1'b0; op_waddr = '0; op_wdata = '0; op_re = 1'b0; op_raddr = '0;
        fc_we = 1'b0; fc_waddr = '0; fc_wdata = '0; fc_re = 1'b0; fc_raddr = '0;
        ns_we = 1'b0; ns_waddr = '0; ns_wdata = '0; ns_re = 1'b0; ns_raddr = '0;
        lc_we = 1'b0; lc_waddr = '0; lc_wdata = '0; lc_re = 1'b0; lc_raddr = '0;
        lb_we = 1'b0; lb_waddr = '0; lb_wdata = '0; lb_re = 1'b0; lb_raddr = '0;
        wq_we = 1'b0; wq_waddr = '0; wq_wdata = '0; wq_re = 1'b0; wq_raddr = '0;

        case (r_state)
            S_CLR: begin
                ch_we = 1'b1; ch_waddr = r_clr;
                fl_we = 1'b1; fl_waddr = r_clr[NODE_W-1:0];
                ef_we = 1'b1; ef_waddr = r_clr[NODE_W-1:0];
                ov_we = 1'b1; ov_waddr = r_clr[NODE_W-1:0];
                fc_we = 1'b1; fc_waddr = r_clr[NODE_W-1:0];
                ns_we = 1'b1; ns_waddr = r_clr[NODE_W-1:0];
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sym = s_axis_tdata[SYM_W-1:0];
                    n_pid = s_axis_tdata[SYM_W +: PID_W];
                    n_last = s_axis_tlast;
                    n_res_found = 1'b0;
                    n_res_pat = '0;
                    n_res_full = 1'b0;
                    n_steps = '0;
                    case (s_axis_tuser)
                        OP_ADD: n_state = S_A0;
                        OP_BUILD: begin
                            wq_we = 1'b1; wq_waddr = '0; wq_wdata = '0;
                            n_head = '0;
                            n_tail = CNT_W'(1);
                            n_state = S_B_POP;
                        end
                        OP_MATCH: begin
                            n_s = r_mc;
                            n_state = S_M_LOOK;
                        end
                        OP_RESTART: begin
                            n_mc = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_A0: begin
                ch_re = 1'b1; ch_raddr = {r_ins, r_sym};
                fc_re = 1'b1; fc_raddr = r_ins;
                lc_re = 1'b1; lc_raddr = r_ins;
                n_state = S_A1;
            end
            S_A1: begin
                n_state = S_DONE;
                if (ch_rdata != '0) begin
                    if (r_last) begin
                        ef_we = 1'b1; ef_waddr = ch_rdata; ef_wdata = 1'b1;
                        ow_we = 1'b1; ow_waddr = ch_rdata; ow_wdata = r_pid;
                        n_ins = '0;
                    end else begin
                        n_ins = ch_rdata;
                    end
                end else if (r_used[NODE_W]) begin
                    n_res_full = 1'b1;
                    if (r_last) begin
                        n_ins = '0;
                    end
                end else begin
                    n_c = r_used[NODE_W-1:0];
                    n_p = r_ins;
                    ch_we = 1'b1; ch_waddr = {r_ins, r_sym}; ch_wdata = r_used[NODE_W-1:0];
                    lb_we = 1'b1; lb_waddr = r_used[NODE_W-1:0]; lb_wdata = r_sym;
                    fl_we = 1'b1; fl_waddr = r_used[NODE_W-1:0];
                    ef_we = 1'b1; ef_waddr = r_used[NODE_W-1:0]; ef_wdata = r_last;
                    ow_we = 1'b1; ow_waddr = r_used[NODE_W-1:0]; ow_wdata = r_pid;
                    ov_we = 1'b1; ov_waddr = r_used[NODE_W-1:0];
                    fc_we = 1'b1; fc_waddr = r_used[NODE_W-1:0];
                    ns_we = 1'b1; ns_waddr = r_used[NODE_W-1:0];
                    lc_we = 1'b1; lc_waddr = r_ins; lc_wdata = r_used[NODE_W-1:0];
                    n_used = r_used + 1'b1;
                    n_ins = r_last ? '0 : r_used[NODE_W-1:0];
                    n_state = S_A2;
                end
            end
            S_A2: begin
                if (fc_rdata == '0) begin
                    fc_we = 1'b1; fc_waddr = r_p; fc_wdata = r_c;
                end else begin
                    ns_we = 1'b1; ns_waddr = lc_rdata; ns_wdata = r_c;
                end
                n_state = S_DONE;
            end
            S_B_POP: begin
                if (r_head < r_tail && !r_head[NODE_W]) begin
                    wq_re = 1'b1; wq_raddr = r_head[NODE_W-1:0];
                    n_head = r_head + 1'b1;
                    n_state = S_B_P;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_B_P: begin
                n_p = wq_rdata;
                fc_re = 1'b1; fc_raddr = wq_rdata;
                n_state = S_B_Q0;
            end
            S_B_Q0: begin
                n_q = fc_rdata;
                n_guard = '0;
                n_state = S_B_CHILD;
            end
            S_B_CHILD: begin
                if (r_q == '0 || r_guard[NODE_W]) begin
                    n_state = S_B_POP;
                end else begin
                    n_guard = r_guard + 1'b1;
                    if (!r_tail[NODE_W]) begin
                        wq_we = 1'b1; wq_waddr = r_tail[NODE_W-1:0]; wq_wdata = r_q;
                        n_tail = r_tail + 1'b1;
                    end
                    if (r_p == '0) begin
                        fl_we = 1'b1; fl_waddr = r_q;
                        ov_we = 1'b1; ov_waddr = r_q;
                        op_we = 1'b1; op_waddr = r_q;
                        n_state = S_B_NEXT;
                    end else begin
                        fl_re = 1'b1; fl_raddr = r_p;
                        lb_re = 1'b1; lb_raddr = r_q;
                        n_state = S_B_R0;
                    end
                end
            end
            S_B_R0: begin
                n_r = fl_rdata;
                n_lbl = lb_rdata;
                n_steps = '0;
                n_state = S_B_LOOK;
            end
            S_B_LOOK: begin
                ch_re = 1'b1; ch_raddr = {r_r, r_lbl};
                n_state = S_B_LOOKW;
            end
            S_B_LOOKW: begin
                if (ch_rdata != '0) begin
                    n_c = ch_rdata;
                    n_state = S_B_F;
                end else if (r_r == '0 || r_steps[NODE_W]) begin
                    n_c = '0;
                    n_state = S_B_F;
                end else begin
                    fl_re = 1'b1; fl_raddr = r_r;
                    n_steps = r_steps + 1'b1;
                    n_state = S_B_RR;
                end
            end
            S_B_RR: begin
                n_r = fl_rdata;
                n_state = S_B_LOOK;
            end
            S_B_F: begin
                fl_we = 1'b1; fl_waddr = r_q; fl_wdata = r_c;
                ef_re = 1'b1; ef_raddr = r_c;
                ow_re = 1'b1; ow_raddr = r_c;
                ov_re = 1'b1; ov_raddr = r_c;
                op_re = 1'b1; op_raddr = r_c;
                n_state = S_B_F2;
            end
            S_B_F2: begin
                ov_we = 1'b1; ov_waddr = r_q;
                op_we = 1'b1; op_waddr = r_q;
                ov_wdata = ef_rdata | ov_rdata;
                op_wdata = ef_rdata ? ow_rdata : op_rdata;
                n_state = S_B_NEXT;
            end
            S_B_NEXT: begin
                ns_re = 1'b1; ns_raddr = r_q;
                n_state = S_B_NEXTW;
            end
            S_B_NEXTW: begin
                n_q = ns_rdata;
                n_state = S_B_CHILD;
            end
            S_M_LOOK: begin
                ch_re = 1'b1; ch_raddr = {r_s, r_sym};
                n_state = S_M_W;
            end
            S_M_W: begin
                if (ch_rdata != '0) begin
                    n_s = ch_rdata;
                    n_mc = ch_rdata;
                    ef_re = 1'b1; ef_raddr = ch_rdata;
                    ow_re = 1'b1; ow_raddr = ch_rdata;
                    ov_re = 1'b1; ov_raddr = ch_rdata;
                    op_re = 1'b1; op_raddr = ch_rdata;
                    n_state = S_M_R;
                end else if (r_s == '0 || r_steps[NODE_W]) begin
                    n_mc = '0;
                    n_state = S_DONE;
                end else begin
                    fl_re = 1'b1; fl_raddr = r_s;
                    n_steps = r_steps + 1'b1;
                    n_state = S_M_FR;
                end
            end
            S_M_FR: begin
                n_s = fl_rdata;
                n_state = S_M_LOOK;
            end
            S_M_R: begin
                n_res_found = ef_rdata | ov_rdata;
                if (ef_rdata) begin
                    n_res_pat = ow_rdata;
                end else if (ov_rdata) begin
                    n_res_pat = op_rdata;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1;
                    n_ofound = r_res_found;
                    n_opat = r_res_pat;
                    n_ofull = r_res_full;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ins   <= '0;
            r_mc    <= '0;
            r_used  <= CNT_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ins   <= n_ins;
            r_mc    <= n_mc;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;     r_pid <= n_pid;     r_last <= n_last;
        r_head <= n_head;   r_tail <= n_tail;   r_guard <= n_guard; r_steps <= n_steps;
        r_p <= n_p;         r_q <= n_q;         r_r <= n_r;         r_lbl <= n_lbl;
        r_c <= n_c;         r_s <= n_s;
        r_res_found <= n_res_found;
        r_res_pat   <= n_res_pat;
        r_res_full  <= n_res_full;
        r_ofound <= n_ofound;
        r_opat   <= n_opat;
        r_ofull  <= n_ofull;
    end

endmodule

// ===== src/mpbm_checker.sv =====
module mpbm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mpbm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mpbm_pkg::*;

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("pattern without match");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9])
            && m_axis_tdata[15:10] == 6'd0)
        else $error("match and full together or padding set");

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/sv/tb_multi_pattern_byte_matcher.sv =====
module tb_multi_pattern_byte_matcher;
    import mpbm_pkg::*;

    typedef struct packed {
        logic       full;
        logic [7:0] pattern;
        logic       found;
    } t_match_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;  // data_byte, pattern_id
    logic [OP_W-1:0]       s_axis_tuser;  // operation
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // match_found, match_pattern, table_full

    multi_pattern_byte_matcher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // trie mirror
    logic [7:0] trie_child [0:65535];
    logic [7:0] fail_link [0:255];
    logic       is_end [0:255];
    logic [7:0] end_id [0:255];
    logic       has_out [0:255];
    logic [7:0] out_id [0:255];
    logic [7:0] first_kid [0:255];
    logic [7:0] next_sib [0:255];
    logic [7:0] last_kid [0:255];
    logic [7:0] edge_sym [0:255];
    int unsigned used_nodes;
    logic [7:0]  ins_node;
    logic [7:0]  scan_node;

    t_match_result expected_results[$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  hits_seen;
    int  full_seen;
    int  idle_cycles = 0;
    bit  rx_hold;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic trie_reset();
        for (int k = 0; k < 65536; k++) trie_child[k] = '0;
        for (int k = 0; k < 256; k++) begin
            fail_link[k] = '0; is_end[k] = 0; end_id[k] = '0; has_out[k] = 0;
            out_id[k] = '0; first_kid[k] = '0; next_sib[k] = '0;
            last_kid[k] = '0; edge_sym[k] = '0;
        end
        used_nodes = 1;
        ins_node   = '0;
        scan_node  = '0;
    endtask

    function automatic void link_trie();
        logic [7:0] bfs[$];
        logic [7:0] p, q, r, f;
        int steps;
        bfs = {bfs, 8'd0};
        while (bfs.size() > 0) begin
            p = bfs.pop_front();
            q = first_kid[p];
            while (q != 0) begin
                bfs = {bfs, q};
                if (p == 0) begin
                    fail_link[q] = '0; has_out[q] = 0; out_id[q] = '0;
                end else begin
                    r = fail_link[p];
                    steps = 0;
                    f = '0;
                    forever begin
                        if (trie_child[{r, edge_sym[q]}] != 0) begin
                            f = trie_child[{r, edge_sym[q]}];
                            break;
                        end
                        if (r == 0 || steps >= 256) break;
                        r = fail_link[r];
                        steps++;
                    end
                    fail_link[q] = f;
                    if (is_end[f]) begin
                        has_out[q] = 1; out_id[q] = end_id[f];
                    end else begin
                        has_out[q] = has_out[f]; out_id[q] = out_id[f];
                    end
                end
                q = next_sib[q];
            end
        end
    endfunction

    function automatic t_match_result predict_match(logic [1:0] op, logic [7:0] sym,
                                                    logic [7:0] pid, logic last);
        t_match_result res;
        logic [7:0] p, c, s;
        int steps;
        bit hit;
        res = '0;
        case (op)
            OP_ADD: begin
                p = ins_node;
                c = trie_child[{p, sym}];
                if (c == 0 && used_nodes >= NODE_COUNT) begin
                    res.full = 1'b1;
                    if (last) ins_node = '0;
                end else begin
                    if (c == 0) begin
                        c = used_nodes[7:0];
                        used_nodes++;
                        trie_child[{p, sym}] = c;
                        edge_sym[c] = sym; fail_link[c] = '0; is_end[c] = 0;
                        has_out[c] = 0; first_kid[c] = '0; next_sib[c] = '0;
                        if (first_kid[p] == 0) first_kid[p] = c;
                        else next_sib[last_kid[p]] = c;
                        last_kid[p] = c;
                    end
                    if (last) begin
                        is_end[c] = 1; end_id[c] = pid; ins_node = '0;
                    end else begin
                        ins_node = c;
                    end
                end
            end
            OP_BUILD: link_trie();
            OP_MATCH: begin
                s = scan_node;
                steps = 0;
                hit = 0;
                forever begin
                    c = trie_child[{s, sym}];
                    if (c != 0) begin
                        s = c; hit = 1; break;
                    end
                    if (s == 0 || steps >= 256) begin
                        s = '0; break;
                    end
                    s = fail_link[s];
                    steps++;
                end
                scan_node = s;
                if (hit && is_end[s]) begin
                    res.found = 1'b1; res.pattern = end_id[s];
                end else if (hit && has_out[s]) begin
                    res.found = 1'b1; res.pattern = out_id[s];
                end
            end
            default: scan_node = '0;
        endcase
        return res;
    endfunction

    task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [7:0] pid, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pid, sym};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results = {expected_results, predict_match(op, sym, pid, last)};
        items_sent++;
        @(negedge i_clk);
        // burst gaps
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(negedge i_clk);
    endtask

    task automatic add_pattern(logic [7:0] bytes[$], logic [7:0] pid);
        for (int k = 0; k < bytes.size(); k++)
            send_item(OP_ADD, bytes[k], pid, k == bytes.size() - 1);
    endtask

    task automatic test_directed();
        add_pattern('{8'h68, 8'h65}, 8'd1);            // he
        add_pattern('{8'h73, 8'h68, 8'h65}, 8'd2);     // she
        add_pattern('{8'h68, 8'h69, 8'h73}, 8'd255);   // his
        add_pattern('{8'h68, 8'h65}, 8'd0);            // duplicate overwrites id
        add_pattern('{8'h00, 8'hff}, 8'd7);
        send_item(OP_BUILD, 8'h00, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h73, 8'hff, 1'b1);
        send_item(OP_MATCH, 8'h68, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h65, 8'h00, 1'b0);
        send_item(OP_RESTART, 8'hff, 8'hff, 1'b1);
        send_item(OP_MATCH, 8'h68, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h69, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h73, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h00, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'hff, 8'h00, 1'b0);
        // add after build: new node fails to root until next build
        add_pattern('{8'h65, 8'h78}, 8'd9);
        send_item(OP_MATCH, 8'h65, 8'h00, 1'b0);
        send_item(OP_MATCH, 8'h78, 8'h00, 1'b0);
        drain_results();
    endtask

    task automatic test_random_text(int count);
        logic [7:0] alpha;
        int len;
        int n;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        alpha = 8'(8'h61 + $urandom_range(0, 3));
                        if ($urandom_range(0, 15) == 0) alpha = 8'($urandom);
                        send_item(OP_ADD, alpha, 8'($urandom), k == len - 1);
                        n++;
                    end
                end
                3: begin
                    send_item(OP_BUILD, 8'($urandom), 8'($urandom), 1'($urandom));
                    n++;
                end
                4: begin
                    send_item(OP_RESTART, 8'($urandom), 8'($urandom), 1'($urandom));
                    n++;
                end
                default: begin
                    alpha = 8'(8'h61 + $urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) alpha = 8'($urandom);
                    send_item(OP_MATCH, alpha, 8'($urandom), 1'($urandom));
                    n++;
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(OP_MATCH, 8'(8'h61 + $urandom_range(0, 3)), 8'($urandom),
                      1'($urandom));
        drain_results();
    endtask

    task automatic test_table_full();
        // fill the table with long fresh chains
        while (used_nodes < NODE_COUNT)
            send_item(OP_ADD, 8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
        add_pattern('{8'h5a, 8'ha5, 8'h3c}, 8'd200);
        send_item(OP_ADD, 8'h11, 8'h22, 1'b0);
        send_item(OP_ADD, 8'h12, 8'h23, 1'b1);
        send_item(OP_BUILD, 8'h00, 8'h00, 1'b0);
        for (int k = 0; k < 60; k++)
            send_item(k % 17 == 0 ? OP_RESTART : OP_MATCH, 8'($urandom), 8'($urandom),
                      1'($urandom));
        drain_results();
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            m_axis_tready <= (($urandom_range(0, 3) != 0) || (results_seen % 64 > 40));
        end
    end

    always @(posedge i_clk) begin
        t_match_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_match_result'(m_axis_tdata[9:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                if (got.found) hits_seen++;
                if (got.full) full_seen++;
                if (got.found !== want.found)
                    $display("%0t: match_found expected %0d actual %0d",
                             $realtime, want.found, got.found);
                if (got.pattern !== want.pattern)
                    $display("%0t: match_pattern expected %0d actual %0d",
                             $realtime, want.pattern, got.pattern);
                if (got.full !== want.full)
                    $display("%0t: table_full expected %0d actual %0d",
                             $realtime, want.full, got.full);
                if (got !== want) errors++;
                if (m_axis_tdata[15:10] !== '0) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %h", $realtime,
                             m_axis_tdata[15:10]);
                end
            end
        end
    end

    // watchdog: clearing sweep plus slowest builds fit well under the limit
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0; items_sent = 0; results_seen = 0; hits_seen = 0; full_seen = 0;
        rx_hold = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = OP_ADD; s_axis_tlast = 1'b0;
        trie_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random_text(150);
        drain_results();
        test_table_full();
        repeat (50) @(negedge i_clk);
        $display("sent %0d items, checked %0d results, %0d pattern hits, %0d table-full",
                 items_sent, results_seen, hits_seen, full_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== multi_pattern_byte_matcher.f =====
src/mpbm_pkg.sv
src/mpbm_ram.sv
src/multi_pattern_byte_matcher.sv
src/mpbm_checker.sv
tb/sv/tb_multi_pattern_byte_matcher.sv
